// ===== hdl/png_scanline_unfilter_macros.svh =====
// Assertion macros shared by the scanline unfilter modules.
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define PSU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define PSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define PSU_ASSERT(lbl, clk, rst_n, prop)
`define PSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/psu_pkg.sv =====
// Shared types, constants and tables for the PNG scanline unfilter.
`timescale 1ns / 1ps

package psu_pkg;

    // Configuration register widths.
    localparam int ROW_PIXELS_W = 13;
    localparam int ROW_COUNT_W  = 16;
    localparam int CHANNELS_W   = 3;

    // Configuration register indexes.
    localparam logic [1:0] REG_ROW_PIXELS      = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT       = 2'd1;
    localparam logic [1:0] REG_SOURCE_CHANNELS = 2'd2;

    // Fault codes.
    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_FILTER  = 2'd1;
    localparam logic [1:0] FAULT_OVERRUN = 2'd2;

    // Channel codes and the alpha pad value.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;
    localparam logic [7:0] ALPHA_PAD = 8'hFF;

    // Highest legal filter type and the RGB channel count.
    localparam logic [7:0] FILTER_MAX   = 8'd4;
    localparam logic [2:0] CHANNELS_RGB = 3'd3;

    // Output queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Reconstruction kinds; the top-row forms see an all-zero upper row.
    typedef enum logic [2:0] {
        K_NONE      = 3'd0,
        K_SUB       = 3'd1,
        K_UP        = 3'd2,
        K_AVG       = 3'd3,
        K_PAETH     = 3'd4,
        K_AVG_TOP   = 3'd5,
        K_PAETH_TOP = 3'd6
    } t_kind;

    // One result as it leaves the block.
    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [1:0] channel;
        logic       last;
        logic       row_done;
        logic       image_done;
        logic [1:0] fault;
    } t_result;

    // Zero, one or two results pushed into the output queue in one cycle.
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

    // Filter type to reconstruction kind on the first row of the image.
    function automatic t_kind top_row_kind(input logic [2:0] ftype);
        t_kind k;
        case (ftype)
            3'd1:    k = K_SUB;
            3'd3:    k = K_AVG_TOP;
            3'd4:    k = K_PAETH_TOP;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/psu_recon.sv =====
// Byte reconstruction for the five PNG filter types, including the Paeth predictor.
`timescale 1ns / 1ps

module psu_recon (
    input  psu_pkg::t_kind i_kind,
    input  logic [7:0]     i_sample,
    input  logic [7:0]     i_left,
    input  logic [7:0]     i_up,
    input  logic [7:0]     i_upleft,
    output logic [7:0]     o_value
);
    import psu_pkg::*;

    logic       top_row;
    logic [7:0] up_b;
    logic [7:0] upleft_c;
    logic [8:0] sum_ab;
    logic [9:0] p_est;
    logic [8:0] dist_a;
    logic [8:0] dist_b;
    logic [8:0] dist_c;
    logic [7:0] paeth;

    // Distance between the Paeth estimate and one neighbor.
    function automatic logic [8:0] dist10(input logic [9:0] p, input logic [7:0] q);
        logic [9:0] d;
        d = p - {2'b00, q};
        return d[9] ? 9'((~d) + 10'd1) : d[8:0];
    endfunction

    // The top-row kinds predict from a zero upper row.
    assign top_row  = (i_kind == K_AVG_TOP) || (i_kind == K_PAETH_TOP);
    assign up_b     = top_row ? 8'd0 : i_up;
    assign upleft_c = top_row ? 8'd0 : i_upleft;
    assign sum_ab   = {1'b0, i_left} + {1'b0, up_b};

    // Paeth estimate a + b - c and the neighbor closest to it.
    always_comb begin
        p_est  = {2'b00, i_left} + {2'b00, up_b} - {2'b00, upleft_c};
        dist_a = dist10(p_est, i_left);
        dist_b = dist10(p_est, up_b);
        dist_c = dist10(p_est, upleft_c);
        if ((dist_a <= dist_b) && (dist_a <= dist_c)) begin
            paeth = i_left;
        end else if (dist_b <= dist_c) begin
            paeth = up_b;
        end else begin
            paeth = upleft_c;
        end
    end

    // Add the prediction to the filtered sample, modulo 256.
    always_comb begin
        unique case (i_kind)
            K_SUB:                 o_value = i_sample + i_left;
            K_UP:                  o_value = i_sample + up_b;
            K_AVG, K_AVG_TOP:      o_value = i_sample + sum_ab[8:1];
            K_PAETH, K_PAETH_TOP:  o_value = i_sample + paeth;
            default:               o_value = i_sample;
        endcase
    end

endmodule

// ===== hdl/psu_out_queue.sv =====
// Four-entry result queue that takes up to two results a cycle and gives one.
`timescale 1ns / 1ps

`include "png_scanline_unfilter_macros.svh"

module psu_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  psu_pkg::t_push   i_push,
    output logic             o_room,
    output psu_pkg::t_result o_head,
    output logic             o_valid,
    input  logic             i_ready
);
    import psu_pkg::*;

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wptr;
    logic [QPTR_W-1:0]   n_rptr;
    logic [QCNT_W-1:0]   n_count;
    logic                pop;

    // Head of the queue drives the output channel.
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign pop     = o_valid && i_ready;

    // Room for a two-result push regardless of this cycle's transfer.
    assign o_room = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));

    // Pointer and fill-level updates.
    always_comb begin
        n_wptr  = r_wptr + QPTR_W'(i_push.num);
        n_rptr  = pop ? r_rptr + QPTR_W'(1) : r_rptr;
        n_count = r_count + QCNT_W'(i_push.num) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Result storage: the second result lands in the entry after the first.
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wptr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wptr + QPTR_W'(1)] <= i_push.second;
        end
    end

    // A push never overruns the queue.
    `PSU_ASSERT(a_push_fits, i_clk, i_rst_n, (i_push.num != 2'd0) |-> (r_count <= QCNT_W'(QUEUE_DEPTH - 2)))

endmodule

// ===== hdl/png_scanline_unfilter.sv =====
// PNG scanline unfilter: filter reconstruction of 8-bit RGB/RGBA rows with a line store.
//
// Input channel: one decompressed byte per transfer. Each row opens with a filter
// type byte, followed by row_pixels * source_channels filtered samples.
// Output channel: one reconstructed byte per transfer with its channel index and
// last, row_done, image_done and fault flags. With three source channels a 255
// alpha byte follows each pixel and carries the row and image flags.
// Path: the line store read issues at the input transfer, the input byte is registered
// in the reconstruction stage, and the write-back happens as the stage empties, when
// the result enters a four-entry output queue.
// Throughput: one input byte per cycle with four channels while the receiver keeps up.
// With three channels the output port sets the pace at four results per three input bytes.
// A filter byte above 4, or a byte after the last row, yields one fault result;
// after that all input is taken and dropped until reset.
// Reset clears the counters and the configuration to width 1, height 1, RGBA.
// The line store needs no clearing: the first row ignores what it reads from it.
// When the receiver stalls, the queue fills and ready drops once more than two
// results wait while the stage is full; nothing is lost.
// Configuration is to be written over the APB port while idle; the block does not enforce it.
`timescale 1ns / 1ps

`include "png_scanline_unfilter_macros.svh"

module png_scanline_unfilter #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    // Result channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_pixel_byte,
    output logic [1:0]  o_channel,
    output logic        o_last,
    output logic        o_row_done,
    output logic        o_image_done,
    output logic [1:0]  o_fault,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import psu_pkg::*;

    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W   = (WID_W > ROW_PIXELS_W) ? WID_W : ROW_PIXELS_W;
    localparam int ADDR_W  = COL_W + 2;
    localparam int DEPTH   = MAX_WIDTH * 4;

    // One item in the reconstruction stage.
    typedef struct packed {
        logic [7:0]        sample;
        logic [1:0]        ch;
        t_kind             kind;
        logic              top_row;
        logic              first_col;
        logic              pad;
        logic              row_done;
        logic              image_done;
        logic [1:0]        fault;
        logic [ADDR_W-1:0] addr;
    } t_stage;

    // Configuration registers.
    logic [ROW_PIXELS_W-1:0] r_row_pixels;
    logic [ROW_COUNT_W-1:0]  r_row_count;
    logic [CHANNELS_W-1:0]   r_source_channels;

    // Scan position and filter state.
    logic [COL_W-1:0]        r_col;
    logic [1:0]              r_ch;
    logic [ROW_COUNT_W-1:0]  r_row;
    logic                    r_expect;
    logic                    r_stuck;
    t_kind                   r_kind;
    logic [COL_W-1:0]        n_col;
    logic [1:0]              n_ch;
    logic [ROW_COUNT_W-1:0]  n_row;
    logic                    n_expect;
    logic                    n_stuck;
    t_kind                   n_kind;

    // Reconstruction stage.
    logic                    r_s1_valid;
    t_stage                  r_s1;
    logic                    n_s1_valid;
    t_stage                  n_s1;
    logic                    load_s1;
    logic                    adv1;

    // Line store and neighbor pixels.
    logic [7:0]              r_line_mem [DEPTH];
    logic [7:0]              r_line_q;
    logic [7:0]              r_left [4];
    logic [7:0]              r_upleft [4];
    logic                    line_rd;
    logic                    line_wr;
    logic                    row_start;

    logic                    in_xfer;
    logic                    cfg_wr;
    logic                    chans3;
    logic                    pixel_end;
    logic                    row_end;
    logic                    img_end;
    logic [CMP_W-1:0]        pix_ext;
    logic [CMP_W-1:0]        width_ext;
    logic [CMP_W-1:0]        col_next_ext;
    logic [7:0]              nb_left;
    logic [7:0]              nb_up;
    logic [7:0]              nb_upleft;
    logic [7:0]              recon_v;
    logic                    q_room;
    t_push                   push;
    t_result                 head;

    // Configuration writes and reads.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pixels      <= ROW_PIXELS_W'(1);
            r_row_count       <= ROW_COUNT_W'(1);
            r_source_channels <= CHANNELS_W'(4);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ROW_PIXELS:      r_row_pixels      <= pwdata[ROW_PIXELS_W-1:0];
                REG_ROW_COUNT:       r_row_count       <= pwdata[ROW_COUNT_W-1:0];
                REG_SOURCE_CHANNELS: r_source_channels <= pwdata[CHANNELS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROW_PIXELS:      prdata = 32'(r_row_pixels);
            REG_ROW_COUNT:       prdata = 32'(r_row_count);
            REG_SOURCE_CHANNELS: prdata = 32'(r_source_channels);
            default:             prdata = '0;
        endcase
    end

    // Stage handshake: the stage empties when the queue has room for its results.
    assign adv1    = r_s1_valid && q_room;
    assign o_ready = !r_s1_valid || adv1;
    assign in_xfer = i_valid && o_ready;

    // Effective width and pixel/row/image boundaries.
    assign chans3       = (r_source_channels == CHANNELS_RGB);
    assign pixel_end    = (r_ch == CH_ALPHA) || (chans3 && (r_ch == CH_BLUE));
    assign pix_ext      = CMP_W'(r_row_pixels);
    assign width_ext    = (r_row_pixels == '0) ? CMP_W'(1) :
                          (pix_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : pix_ext;
    assign col_next_ext = CMP_W'(r_col) + CMP_W'(1);
    assign row_end      = pixel_end && (col_next_ext >= width_ext);
    assign img_end      = ({1'b0, r_row} + 17'd1) >= {1'b0, r_row_count};

    // Input side: parse filter bytes, step the scan position, fill the stage.
    always_comb begin
        n_col     = r_col;
        n_ch      = r_ch;
        n_row     = r_row;
        n_expect  = r_expect;
        n_stuck   = r_stuck;
        n_kind    = r_kind;
        n_s1      = r_s1;
        load_s1   = 1'b0;
        line_rd   = 1'b0;
        row_start = 1'b0;
        if (in_xfer && !r_stuck) begin
            if (r_expect) begin
                if (r_row >= r_row_count) begin
                    n_stuck  = 1'b1;
                    load_s1  = 1'b1;
                    n_s1       = '0;
                    n_s1.fault = FAULT_OVERRUN;
                end else if (i_data_byte > FILTER_MAX) begin
                    n_stuck  = 1'b1;
                    load_s1  = 1'b1;
                    n_s1       = '0;
                    n_s1.fault = FAULT_FILTER;
                end else begin
                    n_kind    = (r_row == '0) ? top_row_kind(i_data_byte[2:0])
                                              : t_kind'(i_data_byte[2:0]);
                    n_expect  = 1'b0;
                    n_col     = '0;
                    n_ch      = '0;
                    row_start = 1'b1;
                end
            end else begin
                load_s1           = 1'b1;
                line_rd           = 1'b1;
                n_s1.sample       = i_data_byte;
                n_s1.ch           = r_ch;
                n_s1.kind         = r_kind;
                n_s1.top_row      = (r_row == '0);
                n_s1.first_col    = (r_col == '0);
                n_s1.pad          = chans3 && (r_ch == CH_BLUE);
                n_s1.row_done     = row_end;
                n_s1.image_done   = row_end && img_end;
                n_s1.fault        = FAULT_NONE;
                n_s1.addr         = {r_col, r_ch};
                if (pixel_end) begin
                    n_ch = '0;
                    if (row_end) begin
                        n_col    = '0;
                        n_row    = r_row + ROW_COUNT_W'(1);
                        n_expect = 1'b1;
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end else begin
                    n_ch = r_ch + 2'd1;
                end
            end
        end
        if (load_s1) begin
            n_s1_valid = 1'b1;
        end else if (adv1) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_ch       <= '0;
            r_row      <= '0;
            r_expect   <= 1'b1;
            r_stuck    <= 1'b0;
            r_kind     <= K_NONE;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_ch       <= n_ch;
            r_row      <= n_row;
            r_expect   <= n_expect;
            r_stuck    <= n_stuck;
            r_kind     <= n_kind;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_s1 <= n_s1;
        end
    end

    // Line store: read at the input transfer, written back as the stage empties.
    assign line_wr = adv1 && (r_s1.fault == FAULT_NONE);

    always_ff @(posedge i_clk) begin
        if (line_rd) begin
            r_line_q <= r_line_mem[n_s1.addr];
        end
        if (line_wr) begin
            r_line_mem[r_s1.addr] <= recon_v;
        end
    end

    // Neighbors: left and upper-left are zero in the first column, up on the first row.
    assign nb_left   = r_s1.first_col ? 8'd0 : r_left[r_s1.ch];
    assign nb_upleft = r_s1.first_col ? 8'd0 : r_upleft[r_s1.ch];
    assign nb_up     = r_s1.top_row ? 8'd0 : r_line_q;

    psu_recon u_recon (
        .i_kind   (r_s1.kind),
        .i_sample (r_s1.sample),
        .i_left   (nb_left),
        .i_up     (nb_up),
        .i_upleft (nb_upleft),
        .o_value  (recon_v)
    );

    // Left and upper-left pixels are cleared as a row opens and updated per sample.
    always_ff @(posedge i_clk) begin
        if (row_start) begin
            for (int k = 0; k < 4; k++) begin
                r_left[k]   <= 8'd0;
                r_upleft[k] <= 8'd0;
            end
        end else if (line_wr) begin
            r_left[r_s1.ch]   <= recon_v;
            r_upleft[r_s1.ch] <= nb_up;
        end
    end

    // Results for the stage item: a fault, a sample, or a sample and its alpha pad.
    always_comb begin
        push = '0;
        if (r_s1.fault != FAULT_NONE) begin
            push.num         = 2'd1;
            push.first.last  = 1'b1;
            push.first.fault = r_s1.fault;
        end else if (r_s1.pad) begin
            push.num               = 2'd2;
            push.first.pixel_byte  = recon_v;
            push.first.channel     = r_s1.ch;
            push.second.pixel_byte = ALPHA_PAD;
            push.second.channel    = CH_ALPHA;
            push.second.last       = 1'b1;
            push.second.row_done   = r_s1.row_done;
            push.second.image_done = r_s1.image_done;
            push.second.fault      = FAULT_NONE;
        end else begin
            push.num              = 2'd1;
            push.first.pixel_byte = recon_v;
            push.first.channel    = r_s1.ch;
            push.first.last       = 1'b1;
            push.first.row_done   = r_s1.row_done;
            push.first.image_done = r_s1.image_done;
        end
        if (!adv1) begin
            push.num = 2'd0;
        end
    end

    psu_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (q_room),
        .o_head  (head),
        .o_valid (o_valid),
        .i_ready (i_ready)
    );

    assign o_pixel_byte = head.pixel_byte;
    assign o_channel    = head.channel;
    assign o_last       = head.last;
    assign o_row_done   = head.row_done;
    assign o_image_done = head.image_done;
    assign o_fault      = head.fault;

    // Once a fault is taken the block stays stuck until reset.
    `PSU_ASSERT_NEXT(a_stuck_holds, i_clk, i_rst_n, r_stuck, r_stuck)
    // A new line store read never lands while a stalled stage still needs its data.
    `PSU_ASSERT(a_read_when_free, i_clk, i_rst_n, line_rd |-> (!r_s1_valid || adv1))
    // A fault result stands alone with a zero byte.
    `PSU_ASSERT(a_fault_alone, i_clk, i_rst_n, (o_valid && (o_fault != FAULT_NONE)) |-> (o_last && (o_pixel_byte == 8'd0) && !o_row_done))

endmodule
